[hdl/sfq_pkg.sv]
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types, codes and default sizes for the searchable FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sfq_pkg;

    // Default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Port widths, fixed by the interface
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int MPOS_W = 4;
    localparam int CNT_W  = 5;
    localparam int STS_W  = 2;

    // Request operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_FIND    = 3'd2,
        OP_REPLACE = 3'd3,
        OP_READ_AT = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [STS_W-1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2,
        STS_RANGE = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_CAP,
        ST_AT_CAP,
        ST_SCAN,
        ST_OLD_RD,
        ST_NEW_RD,
        ST_FIN
    } t_state;

    // Read address source for single reads
    typedef enum logic [1:0] {
        RD_OLDEST,
        RD_NEWEST,
        RD_AT
    } t_rd_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;       // take a new request
        logic       push;        // write value at tail, count up
        logic       rd_en;       // single read
        t_rd_sel    rd_sel;
        logic       pop_cap;     // capture popped entry, advance head
        logic       at_cap;      // capture read-at entry
        logic       status_we;
        t_status    status_code;
        logic       scan_init;   // clear scan counter
        logic       scan_step;   // one scan cycle
        logic       old_cap;     // capture oldest value
        logic       finish;      // capture newest value, raise done
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic pos_ok;
        logic scan_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[hdl/sfq_ram.sv]
// ----------------------------------------------------------------------------
// sfq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/sfq_ctrl.sv]
// ----------------------------------------------------------------------------
// sfq_ctrl
// Request sequencer: decodes the operation and steps the datapath through
// execute, pop/read-at capture or scan, and the closing oldest/newest reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output      logic             o_busy,
    input  wire sfq_pkg::t_dp_sts i_sts,
    output      sfq_pkg::t_dp_cmd o_cmd
);

    import sfq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                case (i_sts.op)
                    OP_PUSH:    n_state = ST_OLD_RD;
                    OP_POP:     n_state = i_sts.empty ? ST_OLD_RD : ST_POP_CAP;
                    OP_FIND,
                    OP_REPLACE: n_state = i_sts.empty ? ST_OLD_RD : ST_SCAN;
                    OP_READ_AT: begin
                        n_state = (i_sts.empty || !i_sts.pos_ok) ? ST_OLD_RD : ST_AT_CAP;
                    end
                    default:    n_state = ST_OLD_RD;
                endcase
            end
            ST_POP_CAP: n_state = ST_OLD_RD;
            ST_AT_CAP:  n_state = ST_OLD_RD;
            ST_SCAN: begin
                if (i_sts.scan_done) n_state = ST_OLD_RD;
            end
            ST_OLD_RD:  n_state = ST_NEW_RD;
            ST_NEW_RD:  n_state = ST_FIN;
            ST_FIN:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.latch = i_start;
            end
            ST_EXEC: begin
                case (i_sts.op)
                    OP_PUSH: begin
                        if (i_sts.full) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = STS_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    OP_POP: begin
                        if (i_sts.empty) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = STS_EMPTY;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_OLDEST;
                        end
                    end
                    OP_FIND,
                    OP_REPLACE: begin
                        o_cmd.scan_init = 1'b1;
                    end
                    OP_READ_AT: begin
                        if (i_sts.empty) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = STS_EMPTY;
                        end else if (!i_sts.pos_ok) begin
                            o_cmd.status_we   = 1'b1;
                            o_cmd.status_code = STS_RANGE;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RD_AT;
                        end
                    end
                    default: ;
                endcase
            end
            ST_POP_CAP: o_cmd.pop_cap = 1'b1;
            ST_AT_CAP:  o_cmd.at_cap = 1'b1;
            ST_SCAN:    o_cmd.scan_step = 1'b1;
            ST_OLD_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_OLDEST;
            end
            ST_NEW_RD: begin
                o_cmd.old_cap = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_NEWEST;
            end
            ST_FIN:     o_cmd.finish = 1'b1;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[hdl/sfq_datapath.sv]
// ----------------------------------------------------------------------------
// sfq_datapath
// Ring buffer storage, head/count registers, scan counter and result
// registers for the searchable FIFO queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_datapath #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sfq_pkg::t_dp_cmd           i_cmd,
    output      sfq_pkg::t_dp_sts           o_sts,
    input  wire logic [sfq_pkg::OP_W-1:0]   i_operation,
    input  wire logic [sfq_pkg::VAL_W-1:0]  i_value,
    input  wire logic [sfq_pkg::VAL_W-1:0]  i_replacement,
    input  wire logic signed [sfq_pkg::POS_W-1:0] i_position,
    output      logic                       o_done,
    output      logic [sfq_pkg::VAL_W-1:0]  o_result_value,
    output      logic                       o_hit,
    output      logic [sfq_pkg::MPOS_W-1:0] o_match_position,
    output      logic [sfq_pkg::CNT_W-1:0]  o_item_count,
    output      logic                       o_is_empty,
    output      logic [sfq_pkg::VAL_W-1:0]  o_oldest_value,
    output      logic [sfq_pkg::VAL_W-1:0]  o_newest_value,
    output      logic [sfq_pkg::STS_W-1:0]  o_status
);

    import sfq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = ((CW > POS_W) ? CW : POS_W) + 1;

    // Slot of an offset from the head; sum stays below twice the depth
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
        return AW'(sum);
    endfunction

    // Control registers
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_oldest;
    logic [CW-1:0] r_idx;
    logic          r_pend;
    logic          r_done;

    // Request and result registers
    t_op                    r_op;
    logic [DATA_WIDTH-1:0]  r_val;
    logic [DATA_WIDTH-1:0]  r_rep;
    logic signed [POS_W-1:0] r_pos;
    logic [DATA_WIDTH-1:0]  r_result;
    logic                   r_hit;
    logic [CW-1:0]          r_mpos;
    t_status                r_status;
    logic [DATA_WIDTH-1:0]  r_oldest_val;
    logic [DATA_WIDTH-1:0]  r_newest_val;

    // RAM interface
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_rdata;

    logic                  w_empty;
    logic                  w_full;
    logic [CW-1:0]         w_count_m1;
    logic [CW-1:0]         w_idx_m1;
    logic                  w_match;
    logic                  w_scan_more;
    logic signed [IW-1:0]  w_pos_ext;
    logic signed [IW-1:0]  w_cnt_ext;
    logic signed [IW-1:0]  w_at_idx;
    logic                  w_pos_ok;

    // Flags and offsets
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_count_m1  = w_empty ? '0 : r_count - CW'(1);
    assign w_idx_m1    = r_idx - CW'(1);
    assign w_match     = r_pend && (w_rdata == r_val);
    assign w_scan_more = (r_idx != r_count);

    // Signed position: non-negative from head, negative back from tail
    assign w_pos_ext = IW'(r_pos);
    assign w_cnt_ext = $signed(IW'(r_count));
    assign w_at_idx  = r_pos[POS_W-1] ? (w_cnt_ext + w_pos_ext) : w_pos_ext;
    assign w_pos_ok  = r_pos[POS_W-1] ? (w_at_idx >= 0) : (w_pos_ext < w_cnt_ext);

    // Status to controller
    always_comb begin
        o_sts.op        = r_op;
        o_sts.empty     = w_empty;
        o_sts.full      = w_full;
        o_sts.pos_ok    = w_pos_ok;
        o_sts.scan_done = !w_scan_more || ((r_op == OP_FIND) && w_match);
    end

    // Read address mux
    always_comb begin
        w_re = i_cmd.rd_en || (i_cmd.scan_step && w_scan_more);
        if (i_cmd.scan_step) begin
            w_raddr = slot_of(r_oldest, r_idx);
        end else begin
            case (i_cmd.rd_sel)
                RD_OLDEST: w_raddr = r_oldest;
                RD_NEWEST: w_raddr = slot_of(r_oldest, w_count_m1);
                RD_AT:     w_raddr = slot_of(r_oldest, CW'(w_at_idx));
                default:   w_raddr = r_oldest;
            endcase
        end
    end

    // Write port: push at tail, or replacement at the last compared entry
    always_comb begin
        w_we = i_cmd.push || (i_cmd.scan_step && w_match && (r_op == OP_REPLACE));
        if (i_cmd.push) begin
            w_waddr = slot_of(r_oldest, r_count);
            w_wdata = r_val;
        end else begin
            w_waddr = slot_of(r_oldest, w_idx_m1);
            w_wdata = r_rep;
        end
    end

    sfq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Head, count, scan counter, done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_oldest <= '0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.pop_cap) begin
                r_oldest <= slot_of(r_oldest, CW'(1));
                r_count  <= r_count - CW'(1);
            end
            if (i_cmd.scan_init) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step && w_scan_more) begin
                r_idx  <= r_idx + CW'(1);
                r_pend <= 1'b1;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= t_op'(i_operation);
            r_val    <= DATA_WIDTH'(i_value);
            r_rep    <= DATA_WIDTH'(i_replacement);
            r_pos    <= i_position;
            r_result <= '0;
            r_hit    <= 1'b0;
            r_mpos   <= '0;
            r_status <= STS_OK;
        end
        if (i_cmd.pop_cap || i_cmd.at_cap) begin
            r_result <= w_rdata;
            r_hit    <= 1'b1;
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status_code;
        end
        // First match of a find
        if (i_cmd.scan_step && w_match && (r_op == OP_FIND)) begin
            r_hit  <= 1'b1;
            r_mpos <= w_idx_m1;
        end
        if (i_cmd.old_cap) begin
            r_oldest_val <= w_empty ? '0 : w_rdata;
        end
        if (i_cmd.finish) begin
            r_newest_val <= w_empty ? '0 : w_rdata;
        end
    end

    // Result ports
    assign o_done           = r_done;
    assign o_result_value   = VAL_W'(r_result);
    assign o_hit            = r_hit;
    assign o_match_position = MPOS_W'(r_mpos);
    assign o_item_count     = CNT_W'(r_count);
    assign o_is_empty       = w_empty;
    assign o_oldest_value   = VAL_W'(r_oldest_val);
    assign o_newest_value   = VAL_W'(r_newest_val);
    assign o_status         = r_status;

endmodule

`default_nettype wire

[hdl/searchable_fifo_queue.sv]
// ----------------------------------------------------------------------------
// searchable_fifo_queue
// Bounded FIFO queue in a ring buffer with push, pop, find, replace-all and
// read-at-position requests; every request returns one result.
// ----------------------------------------------------------------------------
//
//   channel   handshake             payload
//   -------   -------------------   ------------------------------------------
//   request   start, busy           i_operation, i_value, i_replacement,
//                                   i_position
//   result    o_done (1-cycle)      o_result_value, o_hit, o_match_position,
//                                   o_item_count, o_is_empty, o_oldest_value,
//                                   o_newest_value, o_status
//
// A request is taken when start is high and busy is low; one request at a time.
// From acceptance to the result: push, unused codes and every error case pass
// through execute and the closing oldest/newest reads, and pop and an in-range
// read-at add a capture state. Find and replace-all walk the entries one per cycle
// through the single RAM read port, stopping early on a find hit.
// o_done is high one cycle, in which busy is already low; the receiver cannot stall.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module searchable_fifo_queue #(
    parameter int DEPTH      = sfq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = sfq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic [sfq_pkg::OP_W-1:0]          i_operation,
    input  wire logic [sfq_pkg::VAL_W-1:0]         i_value,
    input  wire logic [sfq_pkg::VAL_W-1:0]         i_replacement,
    input  wire logic signed [sfq_pkg::POS_W-1:0]  i_position,
    output      logic                              o_done,
    output      logic [sfq_pkg::VAL_W-1:0]         o_result_value,
    output      logic                              o_hit,
    output      logic [sfq_pkg::MPOS_W-1:0]        o_match_position,
    output      logic [sfq_pkg::CNT_W-1:0]         o_item_count,
    output      logic                              o_is_empty,
    output      logic [sfq_pkg::VAL_W-1:0]         o_oldest_value,
    output      logic [sfq_pkg::VAL_W-1:0]         o_newest_value,
    output      logic [sfq_pkg::STS_W-1:0]         o_status
);

    import sfq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer
    sfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Storage and result registers
    sfq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_operation      (i_operation),
        .i_value          (i_value),
        .i_replacement    (i_replacement),
        .i_position       (i_position),
        .o_done           (o_done),
        .o_result_value   (o_result_value),
        .o_hit            (o_hit),
        .o_match_position (o_match_position),
        .o_item_count     (o_item_count),
        .o_is_empty       (o_is_empty),
        .o_oldest_value   (o_oldest_value),
        .o_newest_value   (o_newest_value),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire

[hdl/sfq_checker.sv]
// ----------------------------------------------------------------------------
// sfq_checker
// Port-level checks on the searchable FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfq_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_done,
    input wire logic [sfq_pkg::CNT_W-1:0]  o_item_count,
    input wire logic                       o_is_empty,
    input wire logic [sfq_pkg::VAL_W-1:0]  o_oldest_value,
    input wire logic [sfq_pkg::VAL_W-1:0]  o_newest_value
);

    import sfq_pkg::*;

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // A result appears only once the sequencer has returned to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // One result per request: never two strobes back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_is_empty == (o_item_count == '0)))
        else $error("empty flag disagrees with item count");

    // An empty queue reports zero head and tail values
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_is_empty) |-> ((o_oldest_value == '0) && (o_newest_value == '0)))
        else $error("empty queue reports nonzero oldest or newest value");

endmodule

bind searchable_fifo_queue sfq_checker u_sfq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_item_count   (o_item_count),
    .o_is_empty     (o_is_empty),
    .o_oldest_value (o_oldest_value),
    .o_newest_value (o_newest_value)
);

`default_nettype wire

[dv/tb_searchable_fifo_queue.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_searchable_fifo_queue
// Self-checking bench for the searchable FIFO queue. A shadow copy of the ring
// buffer predicts every result at request acceptance; the monitor checks each
// o_done strobe against the oldest prediction. Directed corner requests come
// first, then fill/drain phases of random requests with bursty pacing.
// ----------------------------------------------------------------------------

module tb_searchable_fifo_queue;

    import sfq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;

    // Operation codes the block does not define; they must leave the queue alone
    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int RANDOM_REQS = 900;
    localparam int DRAIN_CYCLES = QDEPTH + 16;

    // One result as seen on the output ports
    typedef struct packed {
        logic [VAL_W-1:0]  result_value;
        logic              hit;
        logic [MPOS_W-1:0] match_pos;
        logic [CNT_W-1:0]  count;
        logic              is_empty;
        logic [VAL_W-1:0]  oldest;
        logic [VAL_W-1:0]  newest;
        logic [STS_W-1:0]  status;
    } t_queue_result;

    // ------------------------------------------------------------------------
    // Shadow queue: predicts results and checks what the block returns
    // ------------------------------------------------------------------------
    class fifo_shadow;
        logic [VAL_W-1:0] ring [QDEPTH];
        logic [3:0]       head;
        logic [CNT_W-1:0] count;
        t_queue_result    pending_results[$];
        int mismatches;
        int unexpected;
        int checked;
        int op_seen [8];
        int full_rejects, empty_errors, range_errors, find_hits, replaced;

        function new();
            head = '0;
            count = '0;
            mismatches = 0;
            unexpected = 0;
            checked = 0;
            full_rejects = 0;
            empty_errors = 0;
            range_errors = 0;
            find_hits = 0;
            replaced = 0;
            foreach (op_seen[k]) op_seen[k] = 0;
            foreach (ring[k]) ring[k] = '0;
        endfunction

        function logic [3:0] slot_at(int off);
            return head + 4'(off);
        endfunction

        // Apply one accepted request to the shadow and queue its result
        function void predict_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] val,
                                      logic [VAL_W-1:0] rep, logic signed [POS_W-1:0] pos);
            t_queue_result r;
            int idx;
            r = '0;
            r.status = STS_OK;
            op_seen[op]++;
            case (op)
                OP_PUSH: begin
                    if (count >= QDEPTH) begin
                        r.status = STS_FULL;
                        full_rejects++;
                    end else begin
                        ring[slot_at(int'(count))] = val;
                        count++;
                    end
                end
                OP_POP: begin
                    if (count == 0) begin
                        r.status = STS_EMPTY;
                        empty_errors++;
                    end else begin
                        r.result_value = ring[head];
                        r.hit = 1'b1;
                        head = head + 4'd1;
                        count--;
                    end
                end
                OP_FIND: begin
                    for (int i = 0; i < int'(count); i++) begin
                        if (ring[slot_at(i)] == val) begin
                            r.hit = 1'b1;
                            r.match_pos = MPOS_W'(i);
                            find_hits++;
                            break;
                        end
                    end
                end
                OP_REPLACE: begin
                    for (int i = 0; i < int'(count); i++) begin
                        if (ring[slot_at(i)] == val) begin
                            ring[slot_at(i)] = rep;
                            replaced++;
                        end
                    end
                end
                OP_READ_AT: begin
                    if (count == 0) begin
                        r.status = STS_EMPTY;
                        empty_errors++;
                    end else begin
                        idx = (pos >= 0) ? int'(pos) : int'(count) + int'(pos);
                        if (idx < 0 || idx >= int'(count)) begin
                            r.status = STS_RANGE;
                            range_errors++;
                        end else begin
                            r.result_value = ring[slot_at(idx)];
                            r.hit = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            r.count = count;
            r.is_empty = (count == 0);
            r.oldest = (count != 0) ? ring[head] : '0;
            r.newest = (count != 0) ? ring[slot_at(int'(count) - 1)] : '0;
            pending_results.push_back(r);
        endfunction

        function void report(string what, t_queue_result exp_r, t_queue_result got);
            if (mismatches + unexpected <= 10) begin
                $display("%0t: %s", $realtime, what);
                $display("  exp val=%h hit=%b mpos=%0d cnt=%0d emp=%b old=%h new=%h sts=%0d",
                         exp_r.result_value, exp_r.hit, exp_r.match_pos, exp_r.count,
                         exp_r.is_empty, exp_r.oldest, exp_r.newest, exp_r.status);
                $display("  got val=%h hit=%b mpos=%0d cnt=%0d emp=%b old=%h new=%h sts=%0d",
                         got.result_value, got.hit, got.match_pos, got.count,
                         got.is_empty, got.oldest, got.newest, got.status);
            end
        endfunction

        function void check_result(t_queue_result got);
            t_queue_result exp_r;
            if (pending_results.size() == 0) begin
                unexpected++;
                report("result with no request outstanding", '0, got);
                return;
            end
            exp_r = pending_results.pop_front();
            checked++;
            if (got !== exp_r) begin
                mismatches++;
                report("result mismatch", exp_r, got);
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int failures();
            return mismatches + unexpected + pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals, instance
    // ------------------------------------------------------------------------
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          req_op = '0;
    logic [VAL_W-1:0]         req_value = '0;
    logic [VAL_W-1:0]         req_replacement = '0;
    logic signed [POS_W-1:0]  req_pos = '0;
    logic                     o_done;
    logic [VAL_W-1:0]         o_result_value;
    logic                     o_hit;
    logic [MPOS_W-1:0]        o_match_position;
    logic [CNT_W-1:0]         o_item_count;
    logic                     o_is_empty;
    logic [VAL_W-1:0]         o_oldest_value;
    logic [VAL_W-1:0]         o_newest_value;
    logic [STS_W-1:0]         o_status;

    fifo_shadow shadow;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    searchable_fifo_queue dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_operation      (req_op),
        .i_value          (req_value),
        .i_replacement    (req_replacement),
        .i_position       (req_pos),
        .o_done           (o_done),
        .o_result_value   (o_result_value),
        .o_hit            (o_hit),
        .o_match_position (o_match_position),
        .o_item_count     (o_item_count),
        .o_is_empty       (o_is_empty),
        .o_oldest_value   (o_oldest_value),
        .o_newest_value   (o_newest_value),
        .o_status         (o_status)
    );

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_queue_result seen;
        if (i_rst_n && o_done === 1'b1) begin
            seen.result_value = o_result_value;
            seen.hit          = o_hit;
            seen.match_pos    = o_match_position;
            seen.count        = o_item_count;
            seen.is_empty     = o_is_empty;
            seen.oldest       = o_oldest_value;
            seen.newest       = o_newest_value;
            seen.status       = o_status;
            shadow.check_result(seen);
        end
    end

    // ------------------------------------------------------------------------
    // Request driver and pacing
    // ------------------------------------------------------------------------
    int burst_left = 0;
    logic [VAL_W-1:0] value_pool [6];

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                                input logic [VAL_W-1:0] rep,
                                input logic signed [POS_W-1:0] pos);
        @(negedge i_clk);
        start           = 1'b1;
        req_op          = op;
        req_value       = val;
        req_replacement = rep;
        req_pos         = pos;
        do @(posedge i_clk); while (busy !== 1'b0);
        shadow.predict_request(op, val, rep, pos);
    endtask

    // Bursts of back-to-back requests separated by idle gaps of random length
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = $urandom_range(1, 30);
            @(negedge i_clk);
            start           = 1'b0;
            req_op          = OP_W'($urandom);
            req_value       = $urandom;
            req_replacement = $urandom;
            req_pos         = POS_W'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [VAL_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    function automatic logic signed [POS_W-1:0] pick_pos(int cnt);
        if (cnt > 0 && $urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1))
                return POS_W'($urandom_range(0, cnt - 1));
            return POS_W'(32 - $urandom_range(1, cnt));
        end
        return POS_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [OP_W-1:0] pick_op(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (r < (filling ? 40 : 10)) return OP_PUSH;
        if (r < 50)                  return OP_POP;
        if (r < 66)                  return OP_FIND;
        if (r < 78)                  return OP_REPLACE;
        if (r < 97)                  return OP_READ_AT;
        return OP_W'($urandom_range(5, 7));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit filling;
        logic [VAL_W-1:0] dup_val;
        shadow = new();
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int k = 2; k < 6; k++) value_pool[k] = $urandom;
        dup_val = value_pool[2];

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: every request but push on an empty queue, including unused codes
        send_request(OP_POP, '0, '0, '0);                 pace();
        send_request(OP_READ_AT, '0, '0, '0);             pace();
        send_request(OP_FIND, '0, '0, '0);                pace();
        send_request(OP_REPLACE, '0, '1, '0);             pace();
        send_request(OP_RSVD5, '1, '1, '1);               pace();
        send_request(OP_RSVD6, '0, '0, '0);               pace();
        send_request(OP_RSVD7, '1, '0, -16);              pace();

        // Fill to the brim with extremes and repeated values, then push once more
        for (int k = 0; k < QDEPTH; k++) begin
            send_request(OP_PUSH, (k == 0) ? '0 : (k == 1) ? '1 :
                         (k % 4 == 2) ? dup_val : $urandom, '0, '0);
            pace();
        end
        send_request(OP_PUSH, '1, '0, '0);                pace();

        // Position -count is the oldest entry; find/replace on duplicates
        send_request(OP_READ_AT, '0, '0, -16);            pace();
        send_request(OP_FIND, dup_val, '0, '0);           pace();
        send_request(OP_REPLACE, dup_val, '1, '0);        pace();
        send_request(OP_POP, '0, '0, '0);                 pace();
        send_request(OP_READ_AT, '0, '0, 15);             pace();

        // Random: alternate fill and drain phases so full and empty recur
        filling = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            logic [OP_W-1:0] op;
            if (shadow.count == QDEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
            else if (shadow.count == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
            else if ($urandom_range(0, 59) == 0) filling = !filling;
            op = pick_op(filling);
            send_request(op, pick_value((op == OP_PUSH) ? 40 : 75), pick_value(50),
                         pick_pos(int'(shadow.count)));
            pace();
        end

        @(negedge i_clk);
        start = 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: push %0d, pop %0d, find %0d, replace %0d, read %0d",
                 shadow.checked, shadow.op_seen[OP_PUSH], shadow.op_seen[OP_POP],
                 shadow.op_seen[OP_FIND], shadow.op_seen[OP_REPLACE],
                 shadow.op_seen[OP_READ_AT]);
        $display("Unused codes %0d, full %0d, empty %0d, range %0d, find hits %0d, %0d replaced",
                 shadow.op_seen[5] + shadow.op_seen[6] + shadow.op_seen[7],
                 shadow.full_rejects, shadow.empty_errors, shadow.range_errors,
                 shadow.find_hits, shadow.replaced);
        if (shadow.failures() == 0) begin
            $display("[searchable_fifo_queue] OK");
        end else begin
            $display("%0d mismatches, %0d unexpected, %0d missing results",
                     shadow.mismatches, shadow.unexpected, shadow.pending());
            $display("[searchable_fifo_queue] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", shadow.pending());
        $display("[searchable_fifo_queue] ERROR");
        $finish;
    end

endmodule
